// File: rtl/core/bfpa_pkg.sv
// Shared constants, types and helpers of the best-fit page allocator.
`timescale 1ns / 1ps
package bfpa_pkg;

	localparam int PAGE_BYTES   = 4096;
	localparam int HEADER_BYTES = 24;
	localparam int MAX_SEGMENTS = 64;
	localparam int HEAP_PAGES   = 65536;

	localparam int ADDR_W     = 28;
	localparam int REQ_W      = 28;
	localparam int PAGES_W    = 17;
	localparam int CNT_W      = $clog2(MAX_SEGMENTS + 1);
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int CMP_W      = PAGES_W + PAGE_SHIFT + 1;

	// Result codes.
	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_ALREADY_FREE = 2'd1,
		ST_NO_ROOM      = 2'd2,
		ST_NOT_SEGMENT  = 2'd3
	} status_t;

	// Operation codes.
	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_EDIT,
		S_RESP
	} state_t;

	// One table entry as held in a cell.
	typedef struct packed {
		logic [PAGES_W-1:0] pages;
		logic               used;
	} entry_t;

	// Edits applied to the table while it streams past in the edit pass.
	typedef struct packed {
		logic               w0_en;
		logic [CNT_W-1:0]   w0_idx;
		entry_t             w0_val;
		logic               w1_en;
		logic [CNT_W-1:0]   w1_idx;
		entry_t             w1_val;
		logic               ins_en;
		logic               rem_en;
		logic [CNT_W-1:0]   mod_idx;
		logic [PAGES_W-1:0] ins_pages;
	} plan_t;

	// Entry at table position idx after the planned overwrites.
	function automatic entry_t apply_writes(entry_t e, logic [CNT_W-1:0] idx, plan_t p);
		entry_t r;
		r = e;
		if (p.w0_en && idx == p.w0_idx) begin
			r = p.w0_val;
		end else if (p.w1_en && idx == p.w1_idx) begin
			r = p.w1_val;
		end
		return r;
	endfunction

endpackage

// File: rtl/core/bfpa_cell.sv
// One cell of the segment chain: holds one entry and takes its neighbor's word on a shift.
`timescale 1ns / 1ps
module bfpa_cell (
	input  logic              clk,
	input  logic              shift,
	input  bfpa_pkg::entry_t  d,
	output bfpa_pkg::entry_t  q
);

	bfpa_pkg::entry_t entry_q;

	// Load the neighbor's entry whenever the chain moves.
	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

// File: rtl/core/best_fit_page_allocator.sv
// Top level of the best-fit page allocator: sequencer and segment cell chain.
`timescale 1ns / 1ps
// The segment table lives in a chain of MAX_SEGMENTS cells that rotates one
// position per clock toward cell 0, where the sequencer reads it, while a
// scan or edit pass runs. A command takes at most two full rotations: a scan
// pass that finds the best fit, the prefix page sums and the segment being
// freed, and an edit pass in which the sequencer rewrites entries and
// inserts or removes one as they come round. A command that succeeds and
// changes the table goes through both passes; a rejected command or a free
// of the last segment skips the edit pass. busy stays high from the
// accepting edge until the cycle after done. done is high for exactly one
// cycle with the word on the result ports; the receiver cannot stall it, so
// it must take the word then.
module best_fit_page_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          op,
	input  logic [bfpa_pkg::REQ_W-1:0]    request_size,
	input  logic [bfpa_pkg::ADDR_W-1:0]   free_address,
	output logic                          done,
	output logic [bfpa_pkg::ADDR_W-1:0]   payload_address,
	output logic [1:0]                    status,
	output logic [bfpa_pkg::PAGES_W-1:0]  heap_top_pages,
	output logic [bfpa_pkg::CNT_W-1:0]    segment_total
);

	localparam int N      = bfpa_pkg::MAX_SEGMENTS;
	localparam int CW     = bfpa_pkg::CNT_W;
	localparam int PW     = bfpa_pkg::PAGES_W;
	localparam int AW     = bfpa_pkg::ADDR_W;
	localparam int XW     = bfpa_pkg::CMP_W;
	localparam int SHIFT  = bfpa_pkg::PAGE_SHIFT;
	localparam int REQ_W_SUM = bfpa_pkg::REQ_W + 1;

	bfpa_pkg::state_t state_q, state_d;

	// Command and global state.
	bfpa_pkg::op_t        op_q;
	logic [PW-1:0]        need_q;
	logic [AW-1:0]        addr_q;
	logic [CW-1:0]        count_q;
	logic [PW-1:0]        break_q;
	logic [CW-1:0]        j_q;

	// Scan pass results.
	logic [PW-1:0]        pre_q;
	logic                 best_v_q, best_pend_q, nxt_free_q;
	logic [CW-1:0]        best_idx_q;
	logic [PW-1:0]        best_pages_q, best_pre_q, nxt_pages_q;
	logic                 hit_v_q, hit_used_q, hit_prev_used_q;
	logic [CW-1:0]        hit_idx_q;
	logic [PW-1:0]        hit_pages_q, hit_prev_pages_q;
	bfpa_pkg::entry_t     last_q;

	// Edit pass state.
	bfpa_pkg::plan_t      plan_q;
	bfpa_pkg::entry_t     hold_q;
	logic                 ins_act_q;

	// Result word.
	logic [AW-1:0]        res_addr_q;
	bfpa_pkg::status_t    res_st_q;

	// Chain wiring.
	bfpa_pkg::entry_t     cell_q [N];
	bfpa_pkg::entry_t     push;
	logic                 shift;

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_cell
			bfpa_pkg::entry_t d_in;
			if (k == N - 1) begin : g_tail
				assign d_in = push;
			end else begin : g_mid
				assign d_in = cell_q[k+1];
			end
			bfpa_cell u_cell (
				.clk   (clk),
				.shift (shift),
				.d     (d_in),
				.q     (cell_q[k])
			);
		end
	endgenerate

	// Entries at the head of the chain, with planned overwrites.
	bfpa_pkg::entry_t head, head_mod, next_mod;
	logic             valid_j, fit, hit_now;
	logic [XW-1:0]    start_addr;
	logic [REQ_W_SUM-1:0] req_sum;

	assign head     = cell_q[0];
	assign head_mod = bfpa_pkg::apply_writes(cell_q[0], j_q, plan_q);
	assign next_mod = bfpa_pkg::apply_writes(cell_q[1], j_q + CW'(1), plan_q);
	assign shift    = (state_q == bfpa_pkg::S_SCAN) || (state_q == bfpa_pkg::S_EDIT);
	assign valid_j  = j_q < count_q;
	assign fit      = valid_j && !head.used && (need_q <= head.pages);
	assign start_addr = XW'({pre_q, {SHIFT{1'b0}}}) + XW'(bfpa_pkg::HEADER_BYTES);
	assign hit_now  = valid_j && !hit_v_q && (start_addr == XW'(addr_q));
	assign req_sum  = {1'b0, request_size} + REQ_W_SUM'(bfpa_pkg::HEADER_BYTES);

	// Word pushed into the tail cell.
	always_comb begin
		push = head;
		if (state_q == bfpa_pkg::S_EDIT) begin
			if (ins_act_q) begin
				push = hold_q;
			end else if (plan_q.ins_en && j_q == plan_q.mod_idx) begin
				push = '{pages: plan_q.ins_pages, used: 1'b0};
			end else if (plan_q.rem_en && j_q >= plan_q.mod_idx) begin
				push = next_mod;
			end else begin
				push = head_mod;
			end
		end
	end

	// Decision after the scan pass.
	bfpa_pkg::plan_t      plan_d;
	bfpa_pkg::status_t    st_d;
	logic [AW-1:0]        addr_d;
	logic [CW-1:0]        count_d;
	logic [PW-1:0]        break_d;
	logic                 edit_d;
	logic [PW-1:0]        rest;
	logic [PW:0]          top_sum;
	logic                 prev_free;

	assign rest      = best_pages_q - need_q;
	assign top_sum   = {1'b0, break_q} + {1'b0, need_q};
	assign prev_free = (hit_idx_q != '0) && !hit_prev_used_q;

	always_comb begin
		plan_d  = '0;
		st_d    = bfpa_pkg::ST_OK;
		addr_d  = '0;
		count_d = count_q;
		break_d = break_q;
		edit_d  = 1'b0;
		if (op_q == bfpa_pkg::OP_ALLOC) begin
			if (!best_v_q) begin
				if (count_q >= CW'(N) || top_sum > (PW+1)'(bfpa_pkg::HEAP_PAGES)) begin
					st_d = bfpa_pkg::ST_NO_ROOM;
				end else begin
					addr_d        = AW'({break_q, {SHIFT{1'b0}}} + XW'(bfpa_pkg::HEADER_BYTES));
					plan_d.w0_en  = 1'b1;
					plan_d.w0_idx = count_q;
					plan_d.w0_val = '{pages: need_q, used: 1'b1};
					count_d       = count_q + CW'(1);
					break_d       = top_sum[PW-1:0];
					edit_d        = 1'b1;
				end
			end else if (best_pages_q != need_q && !nxt_free_q && count_q >= CW'(N)) begin
				st_d = bfpa_pkg::ST_NO_ROOM;
			end else begin
				addr_d        = AW'({best_pre_q, {SHIFT{1'b0}}} + XW'(bfpa_pkg::HEADER_BYTES));
				plan_d.w0_en  = 1'b1;
				plan_d.w0_idx = best_idx_q;
				plan_d.w0_val = '{pages: need_q, used: 1'b1};
				edit_d        = 1'b1;
				if (best_pages_q != need_q) begin
					if (nxt_free_q) begin
						plan_d.w1_en  = 1'b1;
						plan_d.w1_idx = best_idx_q + CW'(1);
						plan_d.w1_val = '{pages: nxt_pages_q + rest, used: 1'b0};
					end else begin
						plan_d.ins_en    = 1'b1;
						plan_d.mod_idx   = best_idx_q + CW'(1);
						plan_d.ins_pages = rest;
						count_d          = count_q + CW'(1);
					end
				end
			end
		end else begin
			if (!hit_v_q) begin
				st_d = bfpa_pkg::ST_NOT_SEGMENT;
			end else if (!hit_used_q) begin
				st_d = bfpa_pkg::ST_ALREADY_FREE;
			end else if (hit_idx_q == count_q - CW'(1)) begin
				// The last segment goes back to the heap top, with its predecessor when that one is free.
				if (prev_free) begin
					break_d = break_q - hit_pages_q - hit_prev_pages_q;
					count_d = count_q - CW'(2);
				end else begin
					break_d = break_q - hit_pages_q;
					count_d = count_q - CW'(1);
				end
			end else if (prev_free) begin
				plan_d.w0_en   = 1'b1;
				plan_d.w0_idx  = hit_idx_q - CW'(1);
				plan_d.w0_val  = '{pages: hit_prev_pages_q + hit_pages_q, used: 1'b0};
				plan_d.rem_en  = 1'b1;
				plan_d.mod_idx = hit_idx_q;
				count_d        = count_q - CW'(1);
				edit_d         = 1'b1;
			end else begin
				plan_d.w0_en  = 1'b1;
				plan_d.w0_idx = hit_idx_q;
				plan_d.w0_val = '{pages: hit_pages_q, used: 1'b0};
				edit_d        = 1'b1;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfpa_pkg::S_IDLE:   if (start) state_d = bfpa_pkg::S_SCAN;
			bfpa_pkg::S_SCAN:   if (j_q == CW'(N - 1)) state_d = bfpa_pkg::S_DECIDE;
			bfpa_pkg::S_DECIDE: state_d = edit_d ? bfpa_pkg::S_EDIT : bfpa_pkg::S_RESP;
			bfpa_pkg::S_EDIT:   if (j_q == CW'(N - 1)) state_d = bfpa_pkg::S_RESP;
			bfpa_pkg::S_RESP:   state_d = bfpa_pkg::S_IDLE;
			default:            state_d = bfpa_pkg::S_IDLE;
		endcase
	end

	// State register and the global counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfpa_pkg::S_IDLE;
			count_q <= '0;
			break_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bfpa_pkg::S_DECIDE) begin
				count_q <= count_d;
				break_q <= break_d;
			end
		end
	end

	// Command capture, scan bookkeeping and edit pass.
	always_ff @(posedge clk) begin
		unique case (state_q)
			bfpa_pkg::S_IDLE: begin
				op_q        <= bfpa_pkg::op_t'(op);
				need_q      <= PW'(req_sum >> SHIFT) + PW'(1);
				addr_q      <= free_address;
				j_q         <= '0;
				pre_q       <= '0;
				best_v_q    <= 1'b0;
				best_pend_q <= 1'b0;
				nxt_free_q  <= 1'b0;
				hit_v_q     <= 1'b0;
				ins_act_q   <= 1'b0;
			end
			bfpa_pkg::S_SCAN: begin
				j_q    <= (j_q == CW'(N - 1)) ? '0 : j_q + CW'(1);
				last_q <= head;
				if (valid_j) begin
					pre_q <= pre_q + head.pages;
				end
				// A strictly smaller fit becomes the best candidate; otherwise record the neighbor of the current one.
				if (fit && (!best_v_q || head.pages < best_pages_q)) begin
					best_v_q     <= 1'b1;
					best_idx_q   <= j_q;
					best_pages_q <= head.pages;
					best_pre_q   <= pre_q;
					best_pend_q  <= 1'b1;
					nxt_free_q   <= 1'b0;
				end else if (best_pend_q) begin
					nxt_free_q  <= valid_j && !head.used;
					nxt_pages_q <= head.pages;
					best_pend_q <= 1'b0;
				end
				if (hit_now) begin
					hit_v_q          <= 1'b1;
					hit_idx_q        <= j_q;
					hit_used_q       <= head.used;
					hit_pages_q      <= head.pages;
					hit_prev_used_q  <= last_q.used;
					hit_prev_pages_q <= last_q.pages;
				end
			end
			bfpa_pkg::S_DECIDE: begin
				plan_q     <= plan_d;
				res_st_q   <= st_d;
				res_addr_q <= addr_d;
			end
			bfpa_pkg::S_EDIT: begin
				j_q <= j_q + CW'(1);
				if (ins_act_q || (plan_q.ins_en && j_q == plan_q.mod_idx)) begin
					hold_q    <= head_mod;
					ins_act_q <= 1'b1;
				end
			end
			bfpa_pkg::S_RESP: begin
				ins_act_q <= 1'b0;
			end
			default: begin
				ins_act_q <= 1'b0;
			end
		endcase
	end

	assign busy            = state_q != bfpa_pkg::S_IDLE;
	assign done            = state_q == bfpa_pkg::S_RESP;
	assign payload_address = res_addr_q;
	assign status          = res_st_q;
	assign heap_top_pages  = break_q;
	assign segment_total   = count_q;

	// The table never holds more entries than there are cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(N))
		else $error("segment count exceeds the number of cells");

	// An accepted command makes the block busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	// After the result word the block is ready again.
	a_done_ready: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block stayed busy after the result word");

	// Heap top and segment count only move when a decision is taken.
	a_state_stable: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) != bfpa_pkg::S_DECIDE |-> ($stable(count_q) && $stable(break_q)))
		else $error("table totals changed outside the decision cycle");

endmodule
